// ===== src/sbbf_pkg.sv =====
package sbbf_pkg;

    // default for the largest filter, as log2 of the block count
    localparam int LOG2_MAX_BLOCKS_DEF = 10;

    // block layout
    localparam int WORDS_PER_BLOCK = 8;
    localparam int WORD_W          = 32;
    localparam int BLOCK_W         = WORDS_PER_BLOCK * WORD_W;
    localparam int POS_W           = 5;
    localparam int POS_LSB         = 27;

    // block count register
    localparam int            BCL_W     = 4;
    localparam logic [BCL_W-1:0] BCL_RESET = 4'd10;

    // command codes carried in tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // split-block salts, one per word
    localparam logic [WORD_W-1:0] SALTS [WORDS_PER_BLOCK] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    // controller to datapath
    typedef struct packed {
        logic rd_issue;
        logic clr_wr;
        logic upd_wr;
        logic res_load;
    } sbbf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic res_stall;
    } sbbf_stat_t;

endpackage

// ===== src/sbbf_ctrl.sv =====
module sbbf_ctrl
    import sbbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  sbbf_stat_t stat,
    output sbbf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.rd_issue  = s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // a query waits until the result slot is free
                if (!(stat.is_query && stat.res_stall))
                begin
                    cmd.upd_wr   = !stat.is_query;
                    cmd.res_load = stat.is_query;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/sbbf_datapath.sv =====
module sbbf_datapath
    import sbbf_pkg::*;
#(
    parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      s_axis_tdata,
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic             maybe_present,
    input  logic             cfg_wr_en,
    input  logic [BCL_W-1:0] cfg_wr_data,
    input  sbbf_cmd_t        cmd,
    output sbbf_stat_t       stat
);

    localparam int AW    = (LOG2_MAX_BLOCKS > 0) ? LOG2_MAX_BLOCKS : 1;
    localparam int DEPTH = 1 << LOG2_MAX_BLOCKS;

    logic [BCL_W-1:0]   bcl_reg;
    logic [BCL_W:0]     n_eff;
    logic [AW-1:0]      blk_mask;
    logic [AW-1:0]      idx_reg;
    logic               query_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [POS_W-1:0]   pos_reg [WORDS_PER_BLOCK];
    logic [WORD_W-1:0]  prod [WORDS_PER_BLOCK];
    logic [BLOCK_W-1:0] bit_mask;
    logic [BLOCK_W-1:0] mem [DEPTH];
    logic [BLOCK_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [BLOCK_W-1:0] wr_data;
    logic               hit;
    logic               out_valid_reg;
    logic               present_reg;

    // block count register; its effective value is saturated to the largest filter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcl_reg <= BCL_RESET;
        end
        else if (cfg_wr_en)
        begin
            bcl_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if ({1'b0, bcl_reg} > (BCL_W+1)'(LOG2_MAX_BLOCKS))
        begin
            n_eff = (BCL_W+1)'(LOG2_MAX_BLOCKS);
        end
        else
        begin
            n_eff = {1'b0, bcl_reg};
        end
        for (int i = 0; i < AW; i++)
        begin
            blk_mask[i] = ((BCL_W+1)'(i) < n_eff);
        end
    end

    // salt products, one lane per word
    always_comb
    begin
        for (int w = 0; w < WORDS_PER_BLOCK; w++)
        begin
            prod[w] = WORD_W'(s_axis_tdata[63:32] * SALTS[w]);
        end
    end

    // item capture on accept
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            idx_reg   <= s_axis_tdata[AW-1:0] & blk_mask;
            query_reg <= (s_axis_tuser == CMD_QUERY);
            for (int w = 0; w < WORDS_PER_BLOCK; w++)
            begin
                pos_reg[w] <= prod[w][POS_LSB +: POS_W];
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // bit mask over the whole block
    always_comb
    begin
        for (int w = 0; w < WORDS_PER_BLOCK; w++)
        begin
            bit_mask[w*WORD_W +: WORD_W] = WORD_W'(1) << pos_reg[w];
        end
    end

    assign hit     = ((rd_data_reg & bit_mask) == bit_mask);
    assign wr_en   = cmd.clr_wr | cmd.upd_wr;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : idx_reg;
    assign wr_data = cmd.clr_wr ? '0 : (rd_data_reg | bit_mask);

    // block store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[s_axis_tdata[AW-1:0] & blk_mask];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            present_reg <= hit;
        end
    end

    assign m_axis_tvalid  = out_valid_reg;
    assign maybe_present  = present_reg;
    assign stat.clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign stat.is_query  = query_reg;
    assign stat.res_stall = out_valid_reg & ~m_axis_tready;

endmodule

// ===== src/split_block_bloom_filter_unit.sv =====
// split-block bloom filter, 256-bit blocks in a single-port block store
// a query result is registered after the block read and the evaluate step, and waits
// while the previous result has not been taken; a new item is accepted only after the
// previous one has been read, then evaluated and, for an insert, written back
// reset: the block store is cleared by a pass that zeroes all 2**LOG2_MAX_BLOCKS blocks
// (1024 by default), with no input transaction accepted; block_count_log2 resets to 10
module split_block_bloom_filter_unit
    import sbbf_pkg::*;
#(
    parameter int LOG2_MAX_BLOCKS = LOG2_MAX_BLOCKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // hash_value
    input  logic             s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // maybe_present, zero fill
    input  logic             cfg_wr_en,
    input  logic [BCL_W-1:0] cfg_wr_data     // block_count_log2
);

    sbbf_cmd_t  cmd;
    sbbf_stat_t stat;
    logic       maybe_present;

    sbbf_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    sbbf_datapath #(
        .LOG2_MAX_BLOCKS (LOG2_MAX_BLOCKS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .maybe_present (maybe_present),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .stat          (stat)
    );

    // result field in the low bit
    assign m_axis_tdata = {7'b0, maybe_present};

endmodule
